// File: hw/rtl/hkm_pkg.sv
// Shared constants and types for the hotkey chord matcher.
package hkm_pkg;

  localparam int TableDepth = 16;
  localparam int IdxW       = (TableDepth > 1) ? $clog2(TableDepth) : 1;
  localparam int CntW       = $clog2(TableDepth + 1);

  localparam int KeyW    = 16;
  localparam int ModW    = 4;
  localparam int OpW     = 3;
  localparam int OutIdxW = 4;
  localparam int NumRegs = 8;
  localparam int RegIdxW = 3;

  localparam logic [OpW-1:0] OpPress   = 3'd0;
  localparam logic [OpW-1:0] OpRelease = 3'd1;
  localparam logic [OpW-1:0] OpAddDown = 3'd2;
  localparam logic [OpW-1:0] OpAddUp   = 3'd3;
  localparam logic [OpW-1:0] OpClear   = 3'd4;

  typedef logic [KeyW-1:0] key_t;
  typedef logic [ModW-1:0] mod_t;

  // Down table entry as stored in RAM.
  typedef struct packed {
    mod_t mods;
    key_t key;
  } down_entry_t;

  typedef struct packed {
    logic                fired;
    logic                table_sel;
    logic [IdxW-1:0]     idx;
    logic                status;
  } result_t;

  localparam key_t CfgReset [NumRegs] = '{
    16'd42, 16'd54, 16'd29, 16'd3613, 16'd56, 16'd3640, 16'd3675, 16'd3676
  };

endpackage

// File: hw/rtl/hotkey_chord_matcher_unit.sv
// Hotkey chord matcher: keydown/keyup hotkey tables with modifier tracking.
//
// Items are taken one at a time. A press or release scans its table(s) one
// entry per cycle through the table RAM read port: the read data is
// registered in the RAM, compared against the key, and once the scan is left
// the result is posted to the output register. The input is stalled while
// an item is in progress. A press scans down_count entries and a release
// max(down_count, up_count), so at most TableDepth (sixteen) entries. Add,
// clear-all and unused operations skip the scan and post their result
// directly. A finished result sits in an output register, so the next item
// is accepted while it waits to be taken; a stalled output only holds the
// block once a second result is ready behind it. The user must write the
// modifier key codes through the configuration port only while the block
// is idle; the block does not enforce this. Writes are taken every cycle.
module hotkey_chord_matcher_unit (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     cfg_valid_i,
  output logic                     cfg_ready_o,
  input  logic [hkm_pkg::RegIdxW-1:0] cfg_index_i,
  input  logic [hkm_pkg::KeyW-1:0] cfg_data_i,
  input  logic                     in_valid_i,
  output logic                     in_stall_o,
  input  logic [hkm_pkg::OpW-1:0]  operation_i,
  input  logic [hkm_pkg::KeyW-1:0] key_code_i,
  input  logic [hkm_pkg::ModW-1:0] mod_mask_i,
  output logic                     out_valid_o,
  input  logic                     out_stall_i,
  output logic                     fired_o,
  output logic                     fired_table_o,
  output logic [hkm_pkg::OutIdxW-1:0] fired_index_o,
  output logic                     status_o
);
  import hkm_pkg::*;

  localparam logic [1:0] StIdle = 2'd0;
  localparam logic [1:0] StScan = 2'd1;
  localparam logic [1:0] StDone = 2'd2;

  logic [1:0]          state_q, state_d;
  key_t                cfg_q [NumRegs];
  logic [OpW-1:0]      op_q, op_d;
  key_t                key_q, key_d;
  logic [CntW-1:0]     down_cnt_q, down_cnt_d;
  logic [CntW-1:0]     up_cnt_q, up_cnt_d;
  logic [TableDepth-1:0] pressed_q, pressed_d;
  mod_t                held_q, held_d;
  logic [CntW-1:0]     scan_q, scan_d;
  logic                cmp_vld_q, cmp_vld_d;
  logic [IdxW-1:0]     cmp_idx_q, cmp_idx_d;
  result_t             res_q, res_d;
  result_t             out_q, out_d;
  logic                out_valid_q, out_valid_d;

  logic                accept;
  logic [CntW-1:0]     limit;
  logic                issue;
  mod_t                groups;
  logic                down_we, up_we;
  down_entry_t         down_wdata, down_rdata;
  key_t                up_rdata;
  logic                down_hit, up_hit;

  hkm_ram #(.Width($bits(down_entry_t)), .Depth(TableDepth)) u_down_ram (
    .clk_i   (clk_i),
    .we_i    (down_we),
    .waddr_i (down_cnt_q[IdxW-1:0]),
    .wdata_i (down_wdata),
    .re_i    (issue),
    .raddr_i (scan_q[IdxW-1:0]),
    .rdata_o (down_rdata)
  );

  hkm_ram #(.Width(KeyW), .Depth(TableDepth)) u_up_ram (
    .clk_i   (clk_i),
    .we_i    (up_we),
    .waddr_i (up_cnt_q[IdxW-1:0]),
    .wdata_i (key_code_i),
    .re_i    (issue),
    .raddr_i (scan_q[IdxW-1:0]),
    .rdata_o (up_rdata)
  );

  assign cfg_ready_o = 1'b1;
  assign in_stall_o  = (state_q != StIdle);
  assign accept      = in_valid_i && (state_q == StIdle);

  assign down_wdata = '{mods: mod_mask_i, key: key_code_i};
  assign down_we    = accept && (operation_i == OpAddDown) &&
                      (down_cnt_q < CntW'(TableDepth));
  assign up_we      = accept && (operation_i == OpAddUp) &&
                      (up_cnt_q < CntW'(TableDepth));

  // Release walks both tables together.
  always_comb begin
    if (op_q == OpRelease && up_cnt_q > down_cnt_q) begin
      limit = up_cnt_q;
    end else begin
      limit = down_cnt_q;
    end
  end

  assign issue = (state_q == StScan) && (scan_q < limit);

  assign down_hit = cmp_vld_q && (CntW'(cmp_idx_q) < down_cnt_q) &&
                    (down_rdata.key == key_q);
  assign up_hit   = cmp_vld_q && (CntW'(cmp_idx_q) < up_cnt_q) && (up_rdata == key_q);

  always_comb begin
    groups = '0;
    for (int b = 0; b < ModW; b++) begin
      if (key_q == cfg_q[2*b] || key_q == cfg_q[2*b+1]) begin
        groups[b] = 1'b1;
      end
    end
  end

  always_comb begin
    state_d     = state_q;
    op_d        = op_q;
    key_d       = key_q;
    down_cnt_d  = down_cnt_q;
    up_cnt_d    = up_cnt_q;
    pressed_d   = pressed_q;
    held_d      = held_q;
    scan_d      = scan_q;
    cmp_vld_d   = 1'b0;
    cmp_idx_d   = cmp_idx_q;
    res_d       = res_q;
    out_d       = out_q;
    out_valid_d = out_valid_q && out_stall_i;

    case (state_q)
      StIdle: begin
        if (accept) begin
          op_d   = operation_i;
          key_d  = key_code_i;
          res_d  = '0;
          scan_d = '0;
          state_d = StDone;
          case (operation_i)
            OpPress, OpRelease: begin
              state_d = StScan;
            end
            OpAddDown: begin
              if (down_we) begin
                pressed_d[down_cnt_q[IdxW-1:0]] = 1'b0;
                down_cnt_d = down_cnt_q + CntW'(1);
              end else begin
                res_d.status = 1'b1;
              end
            end
            OpAddUp: begin
              if (up_we) begin
                up_cnt_d = up_cnt_q + CntW'(1);
              end else begin
                res_d.status = 1'b1;
              end
            end
            OpClear: begin
              down_cnt_d = '0;
              up_cnt_d   = '0;
              pressed_d  = '0;
            end
            default: begin
            end
          endcase
        end
      end
      StScan: begin
        // Issue the read for scan_q while comparing the entry read last cycle.
        cmp_vld_d = issue;
        cmp_idx_d = scan_q[IdxW-1:0];
        if (issue) begin
          scan_d = scan_q + CntW'(1);
        end
        if (op_q == OpPress) begin
          if (down_hit && !pressed_q[cmp_idx_q] && !res_q.fired &&
              ((down_rdata.mods & ~held_q) == '0)) begin
            pressed_d[cmp_idx_q] = 1'b1;
            res_d.fired = 1'b1;
            res_d.idx   = cmp_idx_q;
          end
        end else begin
          if (up_hit && !res_q.fired) begin
            res_d.fired     = 1'b1;
            res_d.table_sel = 1'b1;
            res_d.idx       = cmp_idx_q;
          end
          if (down_hit) begin
            pressed_d[cmp_idx_q] = 1'b0;
          end
        end
        if (!issue && !cmp_vld_q) begin
          state_d = StDone;
        end
      end
      StDone: begin
        // Hold the result until the output register is free.
        if (!out_valid_q || !out_stall_i) begin
          out_d       = res_q;
          out_valid_d = 1'b1;
          state_d     = StIdle;
          if (op_q == OpPress) begin
            held_d = held_q | groups;
          end else if (op_q == OpRelease) begin
            held_d = held_q & ~groups;
          end
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      down_cnt_q  <= '0;
      up_cnt_q    <= '0;
      pressed_q   <= '0;
      held_q      <= '0;
      scan_q      <= '0;
      cmp_vld_q   <= 1'b0;
      out_valid_q <= 1'b0;
      for (int r = 0; r < NumRegs; r++) begin
        cfg_q[r] <= CfgReset[r];
      end
    end else begin
      state_q     <= state_d;
      down_cnt_q  <= down_cnt_d;
      up_cnt_q    <= up_cnt_d;
      pressed_q   <= pressed_d;
      held_q      <= held_d;
      scan_q      <= scan_d;
      cmp_vld_q   <= cmp_vld_d;
      out_valid_q <= out_valid_d;
      if (cfg_valid_i) begin
        cfg_q[cfg_index_i] <= cfg_data_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    op_q      <= op_d;
    key_q     <= key_d;
    cmp_idx_q <= cmp_idx_d;
    res_q     <= res_d;
    out_q     <= out_d;
  end

  assign out_valid_o   = out_valid_q;
  assign fired_o       = out_q.fired;
  assign fired_table_o = out_q.table_sel;
  assign fired_index_o = OutIdxW'(out_q.idx);
  assign status_o      = out_q.status;

endmodule

// File: hw/rtl/hkm_ram.sv
// Generic single-write, single-read RAM with registered read data.
module hkm_ram #(
  parameter int Width = 16,
  parameter int Depth = 16
) (
  input  logic                                          clk_i,
  input  logic                                          we_i,
  input  logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0]  waddr_i,
  input  logic [Width-1:0]                              wdata_i,
  input  logic                                          re_i,
  input  logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0]  raddr_i,
  output logic [Width-1:0]                              rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule
